// ----- rtl/hctd_pkg.sv -----
// hctd_pkg: request and response word types, operation and status codes
// for the huffman code tree decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hctd_pkg;

  localparam int CODE_W  = 15;
  localparam int LEN_W   = 4;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 9;
  localparam int LENGTHS = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DECODE = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_PREFIX  = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]        op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;
    logic              bit_req;
  } req_t;

  typedef struct packed {
    logic               symbol_valid;
    logic [SYM_W-1:0]   decoded_symbol;
    logic [1:0]         status;
    logic [COUNT_W-1:0] length_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/hctd_ram.sv -----
// hctd_ram: generic simple dual-port ram, one write and one registered read
// port. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hctd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/huffman_code_tree_decoder.sv -----
// huffman_code_tree_decoder: decode tree kept in one node ram, bitwise
// decoder walk, code insert and per-length counts. Uses hctd_pkg, hctd_ram.
//
//   channel  word    valid      stall      direction
//   req      req_t   req_valid  req_stall  in
//   rsp      rsp_t   rsp_valid  rsp_stall  out
//
// one word at a time. query, tree reset and bad-length inserts finish in the
// idle state; decode reads the walk node, then its child (dependent node
// reads through the ram read port), stopping early on a missing branch;
// insert reads the existing path, then writes each new node and the leaf.
// after rst the init state clears the root node before req is taken.
// a finished word waits in a holding register while rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_tree_decoder #(
  parameter int MAX_CODE_LEN = 15,
  parameter int NODE_COUNT   = 512,
  parameter int SYMBOL_BITS  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hctd_pkg::req_t req,
  input  wire logic          req_valid,
  output logic               req_stall,
  output hctd_pkg::rsp_t     rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);

  import hctd_pkg::*;

  localparam int NB      = $clog2(NODE_COUNT);
  localparam int NFB     = $clog2(NODE_COUNT + 1);
  localparam int SB      = SYMBOL_BITS;
  localparam int NODE_W  = 2 * NB + 1 + SB;
  localparam int L_LO    = NB + 1 + SB;
  localparam int R_LO    = 1 + SB;
  localparam int LEAF_B  = SB;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_DEC1 = 3'd4;
  localparam logic [2:0] S_DEC2 = 3'd5;
  localparam logic [2:0] S_HOLD = 3'd6;

  localparam logic [NFB-1:0] NODES_V = NFB'(NODE_COUNT);

  logic [2:0]         state, state_next;
  logic [NB-1:0]      walk_pointer, walk_pointer_next;
  logic [NFB-1:0]     next_free, next_free_next;
  logic [NB-1:0]      node, node_next;
  logic [LEN_W-1:0]   pos, pos_next;
  logic [NODE_W-1:0]  base, base_next;
  logic [COUNT_W-1:0] counts [LENGTHS];
  req_t               req_q;
  rsp_t               res_q;

  logic               wr_en;
  logic [NB-1:0]      wr_addr, rd_addr;
  logic [NODE_W-1:0]  wr_data, rd_data;

  logic               fin, cnt_bump, tree_clear, out_free, accept;
  rsp_t               fin_res;

  logic [LEN_W-1:0]   bidx;
  logic [CODE_W:0]    code_ext;
  logic               cur_bit;
  logic [NB-1:0]      rd_left, rd_right, rd_child, dec_child;
  logic               rd_leaf;
  logic [SB+SYM_W-1:0] sym_ext, dsym_ext;
  logic [SB-1:0]      sym_w;
  logic [LEN_W-1:0]   need;
  logic [NFB-1:0]     room;
  logic               len_bad;
  logic [NODE_W-1:0]  with_child, leaf_data;

  hctd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // code bit for the current tree level, msb of the length first
  assign code_ext = {1'b0, req_q.code};
  assign bidx     = req_q.code_length - pos - 4'd1;
  assign cur_bit  = code_ext[bidx];

  assign rd_left   = rd_data[L_LO +: NB];
  assign rd_right  = rd_data[R_LO +: NB];
  assign rd_leaf   = rd_data[LEAF_B];
  assign rd_child  = cur_bit ? rd_right : rd_left;
  assign dec_child = req_q.bit_req ? rd_right : rd_left;

  assign sym_ext  = {{SB{1'b0}}, req_q.symbol};
  assign sym_w    = sym_ext[SB-1:0];
  assign dsym_ext = {{SYM_W{1'b0}}, rd_data[SB-1:0]};

  assign need    = req_q.code_length - pos;
  assign room    = NODES_V - next_free;
  assign len_bad = (req.code_length == '0) ||
                   ({28'd0, req.code_length} > 32'(MAX_CODE_LEN));

  always_comb begin
    with_child = base;
    if (cur_bit) begin
      with_child[R_LO +: NB] = next_free[NB-1:0];
    end else begin
      with_child[L_LO +: NB] = next_free[NB-1:0];
    end
    leaf_data = base;
    leaf_data[LEAF_B] = 1'b1;
    leaf_data[SB-1:0] = sym_w;
  end

  always_comb begin
    state_next        = state;
    walk_pointer_next = walk_pointer;
    next_free_next    = next_free;
    node_next         = node;
    pos_next          = pos;
    base_next         = base;
    rd_addr           = '0;
    wr_en             = 1'b0;
    wr_addr           = node;
    wr_data           = '0;
    fin               = 1'b0;
    fin_res           = '0;
    cnt_bump          = 1'b0;
    tree_clear        = 1'b0;
    case (state)
      S_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_INSERT: begin
              if (len_bad) begin
                fin            = 1'b1;
                fin_res.status = ST_PREFIX;
              end else begin
                rd_addr    = '0;
                node_next  = '0;
                pos_next   = '0;
                state_next = S_CHK;
              end
            end
            OP_DECODE: begin
              rd_addr    = walk_pointer;
              state_next = S_DEC1;
            end
            OP_RESET: begin
              wr_en             = 1'b1;
              wr_addr           = '0;
              tree_clear        = 1'b1;
              next_free_next    = NFB'(1);
              walk_pointer_next = '0;
              fin               = 1'b1;
            end
            OP_QUERY: begin
              fin                  = 1'b1;
              fin_res.length_count = counts[req.code_length];
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_CHK: begin
        // rd_data holds the node at the current level
        if (pos != req_q.code_length) begin
          if (rd_leaf) begin
            fin            = 1'b1;
            fin_res.status = ST_PREFIX;
          end else if (rd_child == '0) begin
            if (32'(need) > 32'(room)) begin
              fin            = 1'b1;
              fin_res.status = ST_FULL;
            end else begin
              base_next  = rd_data;
              state_next = S_WR;
            end
          end else begin
            rd_addr   = rd_child;
            node_next = rd_child;
            pos_next  = pos + 4'd1;
          end
        end else if (rd_left != '0 || rd_right != '0) begin
          fin            = 1'b1;
          fin_res.status = ST_PREFIX;
        end else begin
          base_next  = rd_data;
          state_next = S_WR;
        end
      end
      S_WR: begin
        wr_en = 1'b1;
        if (pos == req_q.code_length) begin
          wr_data  = leaf_data;
          cnt_bump = !base[LEAF_B];
          fin      = 1'b1;
        end else begin
          // hook a fresh node under the current one and step down into it
          wr_data        = with_child;
          base_next      = '0;
          node_next      = next_free[NB-1:0];
          next_free_next = next_free + NFB'(1);
          pos_next       = pos + 4'd1;
        end
      end
      S_DEC1: begin
        if (dec_child == '0) begin
          fin               = 1'b1;
          fin_res.status    = ST_MISSING;
          walk_pointer_next = '0;
        end else begin
          rd_addr    = dec_child;
          node_next  = dec_child;
          state_next = S_DEC2;
        end
      end
      S_DEC2: begin
        fin = 1'b1;
        if (rd_leaf) begin
          fin_res.symbol_valid   = 1'b1;
          fin_res.decoded_symbol = dsym_ext[SYM_W-1:0];
          walk_pointer_next      = '0;
        end else begin
          walk_pointer_next = node;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      walk_pointer <= '0;
      next_free    <= NFB'(1);
      for (int k = 0; k < LENGTHS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      state        <= state_next;
      walk_pointer <= walk_pointer_next;
      next_free    <= next_free_next;
      if (tree_clear) begin
        for (int k = 0; k < LENGTHS; k++) begin
          counts[k] <= '0;
        end
      end else if (cnt_bump && counts[req_q.code_length] != COUNT_MAX) begin
        counts[req_q.code_length] <= counts[req_q.code_length] + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    pos  <= pos_next;
    base <= base_next;
    if (accept) begin
      req_q <= req;
    end
    if (fin && !out_free) begin
      res_q <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin && out_free) begin
      rsp       <= fin_res;
      rsp_valid <= 1'b1;
    end else if (state == S_HOLD && out_free) begin
      rsp       <= res_q;
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- verif/huffman_code_tree_decoder_test.sv -----
// huffman_code_tree_decoder_test: self-checking bench for the huffman code tree
// decoder, with its own tree predictor, directed opening plan and random phases.
// Depends on hctd_pkg and huffman_code_tree_decoder.
`timescale 1ns / 1ps

module huffman_code_tree_decoder_test;
  import hctd_pkg::*;

  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 15;
  localparam int WORD_TARGET  = 1750;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  huffman_code_tree_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // predicted tree
  int unsigned        node_left  [NODE_COUNT];
  int unsigned        node_right [NODE_COUNT];
  bit                 node_leaf  [NODE_COUNT];
  logic [SYM_W-1:0]   node_sym   [NODE_COUNT];
  int unsigned        free_node;
  int unsigned        walk_node;
  logic [COUNT_W-1:0] len_count  [LENGTHS];

  rsp_t due_results [$];
  rsp_t oldest_due;
  int   mismatches;
  int   results_checked;
  int   words_sent;

  // codes the tree currently holds, for well-formed bit streams
  logic [CODE_W-1:0] known_code [$];
  int                known_len  [$];

  typedef struct {
    logic [1:0]         op;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  code;
    logic [LEN_W-1:0]   len;
    logic               b;
    bit                 typed;
    logic               v;
    logic [SYM_W-1:0]   dsym;
    logic [1:0]         st;
    logic [COUNT_W-1:0] cnt;
  } plan_row_t;

  plan_row_t opening_plan [25] = '{
    '{OP_QUERY,  8'h00, 15'h0000, 4'd0,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_MISSING, 9'd0},
    '{OP_DECODE, 8'hff, 15'h7fff, 4'd15, 1'b1, 1, 1'b0, 8'h00, ST_MISSING, 9'd0},
    '{OP_INSERT, 8'h03, 15'h0000, 4'd0,  1'b0, 1, 1'b0, 8'h00, ST_PREFIX,  9'd0},
    '{OP_INSERT, 8'h00, 15'h7ffe, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b0, 1, 1'b1, 8'h00, ST_OK,      9'd0},
    '{OP_INSERT, 8'hff, 15'h0001, 4'd1,  1'b1, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b1, 1, 1'b1, 8'hff, ST_OK,      9'd0},
    '{OP_QUERY,  8'h00, 15'h0000, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd2},
    '{OP_INSERT, 8'h07, 15'h0000, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b0, 1, 1'b1, 8'h07, ST_OK,      9'd0},
    '{OP_QUERY,  8'h00, 15'h0000, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd2},
    '{OP_INSERT, 8'h09, 15'h0001, 4'd2,  1'b0, 1, 1'b0, 8'h00, ST_PREFIX,  9'd0},
    '{OP_RESET,  8'h00, 15'h0000, 4'd0,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_QUERY,  8'h00, 15'h0000, 4'd1,  1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_INSERT, 8'haa, 15'h7fff, 4'd15, 1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_INSERT, 8'h01, 15'h3fff, 4'd14, 1'b0, 1, 1'b0, 8'h00, ST_PREFIX,  9'd0},
    '{OP_QUERY,  8'h00, 15'h0000, 4'd15, 1'b0, 1, 1'b0, 8'h00, ST_OK,      9'd1},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b1, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b1, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_INSERT, 8'h55, 15'h0000, 4'd15, 1'b0, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b0, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_QUERY,  8'h00, 15'h0000, 4'd15, 1'b0, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_DECODE, 8'h00, 15'h0000, 4'd0,  1'b0, 0, 1'b0, 8'h00, ST_OK,      9'd0},
    '{OP_INSERT, 8'h00, 15'h0000, 4'd15, 1'b0, 0, 1'b0, 8'h00, ST_OK,      9'd0}
  };

  function automatic void clear_tree();
    for (int k = 0; k < NODE_COUNT; k++) begin
      node_left[k]  = 0;
      node_right[k] = 0;
      node_leaf[k]  = 1'b0;
      node_sym[k]   = '0;
    end
    for (int k = 0; k < LENGTHS; k++) len_count[k] = '0;
    free_node = 1;
    walk_node = 0;
  endfunction

  function automatic logic [1:0] tree_insert(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                                             int len);
    int unsigned n;
    int unsigned nx;
    int          i;
    int          need;
    n = 0;
    i = 0;
    if (len == 0 || len > MAX_CODE_LEN) return ST_PREFIX;
    // follow the nodes already there
    while (i < len) begin
      if (node_leaf[n]) return ST_PREFIX;
      nx = code[len-1-i] ? node_right[n] : node_left[n];
      if (nx == 0) break;
      n = nx;
      i++;
    end
    need = len - i;
    if (need == 0) begin
      if (node_left[n] != 0 || node_right[n] != 0) return ST_PREFIX;
      if (node_leaf[n]) begin
        node_sym[n] = sym;
        return ST_OK;
      end
    end
    if (need > NODE_COUNT - free_node) return ST_FULL;
    while (i < len) begin
      nx = free_node;
      free_node++;
      node_left[nx]  = 0;
      node_right[nx] = 0;
      node_leaf[nx]  = 1'b0;
      node_sym[nx]   = '0;
      if (code[len-1-i]) node_right[n] = nx;
      else node_left[n] = nx;
      n = nx;
      i++;
    end
    node_leaf[n] = 1'b1;
    node_sym[n]  = sym;
    if (len_count[len] != COUNT_MAX) len_count[len]++;
    return ST_OK;
  endfunction

  function automatic rsp_t predict_tree_step(req_t w);
    rsp_t        r;
    int unsigned nx;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      OP_INSERT: r.status = tree_insert(w.symbol, w.code, int'(w.code_length));
      OP_DECODE: begin
        nx = w.bit_req ? node_right[walk_node] : node_left[walk_node];
        if (nx == 0) begin
          r.status  = ST_MISSING;
          walk_node = 0;
        end else if (node_leaf[nx]) begin
          r.symbol_valid   = 1'b1;
          r.decoded_symbol = node_sym[nx];
          walk_node        = 0;
        end else begin
          walk_node = nx;
        end
      end
      OP_RESET: clear_tree();
      default: r.length_count = len_count[w.code_length];
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t random_word(logic [1:0] op);
    req_t w;
    w.op          = op;
    w.symbol      = SYM_W'($urandom_range(0, 255));
    w.code        = CODE_W'($urandom_range(0, 32767));
    w.code_length = LEN_W'($urandom_range(0, 15));
    w.bit_req     = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_want,
                           output rsp_t forecast);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    forecast = predict_tree_step(w);
    due_results.push_back(typed ? typed_want : forecast);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic insert_word(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input int len, output logic [1:0] st);
    req_t w;
    rsp_t fc;
    w = random_word(OP_INSERT);
    w.symbol      = sym;
    w.code        = code;
    w.code_length = LEN_W'(len);
    send_word(w, 1'b0, '0, fc);
    st = fc.status;
    if (st == ST_OK) begin
      known_code.push_back(code);
      known_len.push_back(len);
    end
  endtask

  task automatic decode_word(input logic b);
    req_t w;
    rsp_t fc;
    w = random_word(OP_DECODE);
    w.bit_req = b;
    send_word(w, 1'b0, '0, fc);
  endtask

  task automatic query_word(input int len);
    req_t w;
    rsp_t fc;
    w = random_word(OP_QUERY);
    w.code_length = LEN_W'(len);
    send_word(w, 1'b0, '0, fc);
  endtask

  task automatic reset_tree_word();
    rsp_t fc;
    send_word(random_word(OP_RESET), 1'b0, '0, fc);
    known_code.delete();
    known_len.delete();
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // insert a handful of codes, then stream their bits back with some noise
  task automatic build_and_decode();
    int         n_ins;
    int         n_steps;
    int         r;
    int         len;
    int         idx;
    logic [1:0] st;
    if ($urandom_range(0, 9) < 8) reset_tree_word();
    n_ins = $urandom_range(1, 24);
    repeat (n_ins) begin
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 85) len = $urandom_range(1, 7);
      else len = $urandom_range(8, 15);
      insert_word(SYM_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 32767)), len, st);
    end
    n_steps = $urandom_range(3, 20);
    repeat (n_steps) begin
      r = $urandom_range(0, 99);
      if (r < 8 || known_len.size() == 0) begin
        decode_word(1'($urandom_range(0, 1)));
      end else if (r < 14) begin
        query_word($urandom_range(0, 15));
      end else if (r < 18) begin
        insert_word(SYM_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 32767)),
                    $urandom_range(1, 15), st);
      end else begin
        idx = $urandom_range(0, known_len.size() - 1);
        for (int i = known_len[idx] - 1; i >= 0; i--) decode_word(known_code[idx][i]);
      end
    end
  endtask

  // long codes until the node store runs out or 120 tries pass, then decode what fits and query every length
  task automatic fill_tree();
    int         fulls;
    int         tries;
    int         idx;
    logic [1:0] st;
    reset_tree_word();
    fulls = 0;
    tries = 0;
    while (fulls < 3 && tries < 120) begin
      insert_word(SYM_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 32767)),
                  $urandom_range(10, 15), st);
      if (st == ST_FULL) fulls++;
      tries++;
    end
    repeat ($urandom_range(2, 5)) begin
      if (known_len.size() != 0) begin
        idx = $urandom_range(0, known_len.size() - 1);
        for (int i = known_len[idx] - 1; i >= 0; i--) decode_word(known_code[idx][i]);
      end
    end
    for (int k = 0; k < LENGTHS; k++) query_word(k);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_results.size() == 0) begin
        $error("response word with nothing expected: %h", rsp);
        mismatches++;
      end else begin
        oldest_due = due_results.pop_front();
        if (rsp.symbol_valid !== oldest_due.symbol_valid) begin
          $error("symbol_valid: expected %0d, got %0d", oldest_due.symbol_valid,
                 rsp.symbol_valid);
          mismatches++;
        end
        if (rsp.decoded_symbol !== oldest_due.decoded_symbol) begin
          $error("decoded_symbol: expected %0d, got %0d", oldest_due.decoded_symbol,
                 rsp.decoded_symbol);
          mismatches++;
        end
        if (rsp.status !== oldest_due.status) begin
          $error("status: expected %0d, got %0d", oldest_due.status, rsp.status);
          mismatches++;
        end
        if (rsp.length_count !== oldest_due.length_count) begin
          $error("length_count: expected %0d, got %0d", oldest_due.length_count,
                 rsp.length_count);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int free_run;
    int hold;
    bit long_done;
    long_done = 1'b0;
    rsp_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!long_done && results_checked >= 200) begin
        long_done = 1'b1;
        rsp_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 8);
      if (free_run > 0) begin
        rsp_stall <= 1'b0;
        repeat (free_run) @(negedge clk);
      end
      hold = pick_gap();
      if (hold == 0) hold = 1;
      rsp_stall <= 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  initial begin
    req_t w;
    rsp_t want;
    rsp_t fc;
    int   phase;
    rst             = 1'b1;
    req             = '0;
    req_valid       = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    words_sent      = 0;
    clear_tree();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_plan[k]) begin
      w.op                = opening_plan[k].op;
      w.symbol            = opening_plan[k].sym;
      w.code              = opening_plan[k].code;
      w.code_length       = opening_plan[k].len;
      w.bit_req           = opening_plan[k].b;
      want.symbol_valid   = opening_plan[k].v;
      want.decoded_symbol = opening_plan[k].dsym;
      want.status         = opening_plan[k].st;
      want.length_count   = opening_plan[k].cnt;
      send_word(w, opening_plan[k].typed, want, fc);
    end
    drain_results();

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      if (phase % 7 == 6) fill_tree();
      else build_and_decode();
      if (phase % 4 == 3) drain_results();
      phase++;
    end

    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
